// File: sv/strip_peak_hit_finder_top_defines.svh
// Assertion macros for the strip peak hit finder checker.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef STRIP_PEAK_HIT_FINDER_TOP_DEFINES_SVH
`define STRIP_PEAK_HIT_FINDER_TOP_DEFINES_SVH

// check cons in the same cycle as ante
`define SPHF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sphf check failed");

// check cons in the cycle after ante
`define SPHF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sphf check failed");

`endif

// File: sv/sphf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and stream layouts for the strip peak hit finder.
// Depends on nothing; used by every module of the block.
package sphf_pkg;

    localparam int CHANNELS = 2048;
    localparam int CHAN_W   = $clog2(CHANNELS);
    localparam int ADC_BITS = 12;

    localparam logic [11:0] ADC_MASK = 12'((1 << ADC_BITS) - 1);

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 96;
    localparam int PED_W      = 32;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SIGMA_THR  = 2'd0,
        REG_STRONG_THR = 2'd1,
        REG_SECTOR     = 2'd2
    } cfg_reg_t;

    localparam logic [9:0] SIGMA_THR_RST  = 10'd80;
    localparam logic [9:0] STRONG_THR_RST = 10'd176;
    localparam logic [2:0] SECTOR_RST     = 3'd6;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_HIT  = 1'b1;

    localparam logic [1:0] LAYER_U = 2'd1;
    localparam logic [1:0] LAYER_V = 2'd2;

    localparam logic signed [10:0] STRIP_NONE = -11'sd1;
    localparam logic signed [4:0]  TIME_NONE  = -5'sd10;
    localparam logic [11:0]        COUNT_MAX  = 12'hFFF;

    // input request, last declared field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] event_number;
        logic [3:0]  time_sample;
        logic [11:0] adc;
        logic [9:0]  strip;
        logic [1:0]  layer;
        logic [2:0]  sector;
        logic [15:0] pedestal_rms;
        logic [15:0] pedestal_mean;
        logic [10:0] channel_index;
    } in_data_t;

    // event result, last declared field in the lowest bits
    typedef struct packed {
        logic [6:0]         pad;
        logic [31:0]        event_id;
        logic [11:0]        strong_count;
        logic [11:0]        hit_count;
        logic signed [4:0]  best_time_v;
        logic signed [4:0]  best_time_u;
        logic signed [10:0] best_strip_v;
        logic signed [10:0] best_strip_u;
        logic               keep_event;
    } out_data_t;

    // verdict on one hit against thresholds and the kept maxima
    typedef struct packed {
        logic               counted;
        logic               strong_hit;
        logic               better_u;
        logic               better_v;
        logic signed [16:0] diff;
    } hit_eval_t;

endpackage

// File: sv/sphf_ped_ram.sv
`timescale 1ns / 1ps
// Pedestal table: one write port and one registered read port, {rms, mean} per channel.
// Depends on sphf_pkg.
module sphf_ped_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [sphf_pkg::CHAN_W-1:0] waddr,
    input  logic [sphf_pkg::PED_W-1:0]  wdata,
    input  logic                        re,
    input  logic [sphf_pkg::CHAN_W-1:0] raddr,
    output logic [sphf_pkg::PED_W-1:0]  rdata
);
    import sphf_pkg::*;

    logic [PED_W-1:0] mem [CHANNELS];
    logic [PED_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/sphf_hit_eval.sv
`timescale 1ns / 1ps
// Threshold tests and peak comparison for one hit, all by cross-multiplication.
// Depends on sphf_pkg.
module sphf_hit_eval (
    input  logic [15:0]         mean,
    input  logic [15:0]         rms,
    input  logic [11:0]         adc,
    input  logic [9:0]          sigma_thr,
    input  logic [9:0]          strong_thr,
    input  logic signed [16:0]  best_diff_u,
    input  logic [15:0]         best_rms_u,
    input  logic signed [16:0]  best_diff_v,
    input  logic [15:0]         best_rms_v,
    output sphf_pkg::hit_eval_t verdict
);
    import sphf_pkg::*;

    logic [11:0]        adc_m;
    logic signed [17:0] diff;
    logic signed [27:0] diff_x16;
    logic [25:0]        sigma_prod;
    logic [25:0]        strong_prod;
    logic signed [34:0] new_x_u;
    logic signed [34:0] new_x_v;
    logic signed [33:0] old_x_u;
    logic signed [33:0] old_x_v;

    assign adc_m    = adc & ADC_MASK;
    // signed 12.4 difference: mean minus adc scaled to 1/16 units
    assign diff     = $signed({2'b00, mean}) - $signed({2'b00, adc_m, 4'b0000});
    assign diff_x16 = $signed({{6{diff[17]}}, diff, 4'b0000});

    assign sigma_prod  = sigma_thr * rms;
    assign strong_prod = strong_thr * rms;

    assign new_x_u = diff * $signed({1'b0, best_rms_u});
    assign new_x_v = diff * $signed({1'b0, best_rms_v});
    assign old_x_u = best_diff_u * $signed({1'b0, rms});
    assign old_x_v = best_diff_v * $signed({1'b0, rms});

    always_comb
    begin
        verdict.counted    = (rms != 16'd0) && (diff_x16 > $signed({2'b00, sigma_prod}));
        verdict.strong_hit = diff_x16 > $signed({2'b00, strong_prod});
        // strict compare keeps the earlier of two equal ratios
        verdict.better_u   = new_x_u > $signed({old_x_u[33], old_x_u});
        verdict.better_v   = new_x_v > $signed({old_x_v[33], old_x_v});
        verdict.diff       = diff[16:0];
    end

endmodule

// File: sv/strip_peak_hit_finder_top.sv
`timescale 1ns / 1ps
// Strip peak hit finder top level: input register, pedestal table, event tracking
// and result register. Depends on sphf_pkg, sphf_ped_ram and sphf_hit_eval.
//
// Usage:
//   Input stream (s_*): tuser = mode (0 load pedestal, 1 hit), tlast = last hit of
//   the event, tdata = packed request fields. A load writes the pedestal mean and
//   RMS of one channel into the table as it is accepted; a hit reads them back.
//   Output stream (m_*): one event result per hit request that carries tlast.
//   Configuration (cfg_we, cfg_index, cfg_data): write thresholds and the wanted
//   sector while the block is idle; a write takes effect at the next edge.
//   Path: an accepted last hit is held in the input register while the table is
//   read; it is then evaluated and loaded into the result register once that is free.
//   Throughput: one request per cycle unless a last hit waits for the result register.
//   The per-event maxima loop back through the hit evaluator, which sets the clock limit.
//   Stall: non-last hits and loads keep flowing while a result waits; a last hit
//   holds in the input register only while the result register is still full.
//   Reset: thresholds return to 5.0 and 11.0 sigma, sector to 6, per-event state
//   is cleared; the pedestal table is not cleared and must be loaded before use.
module strip_peak_hit_finder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: channel_index, pedestal_mean, pedestal_rms, sector, layer, strip,
    //        adc, time_sample, event_number, zero fill
    input  logic [sphf_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: mode
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: keep_event, best_strip_u, best_strip_v, best_time_u, best_time_v,
    //        hit_count, strong_count, event_id, zero fill
    output logic [sphf_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [9:0]                      cfg_data
);
    import sphf_pkg::*;

    in_data_t in_d;
    logic     s_accept;
    logic     in_is_hit;
    logic     in_range;

    // configuration
    logic [9:0] sigma_thr_reg;
    logic [9:0] strong_thr_reg;
    logic [2:0] sector_reg;

    // input register stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [2:0]  s1_sector_reg;
    logic [1:0]  s1_layer_reg;
    logic [9:0]  s1_strip_reg;
    logic [11:0] s1_adc_reg;
    logic [3:0]  s1_time_reg;
    logic [31:0] s1_event_reg;
    logic        s1_last_reg;
    logic        s1_in_range_reg;
    logic        s1_fire;

    logic [PED_W-1:0] ped_rdata;
    logic [15:0]      ped_mean;
    logic [15:0]      ped_rms;
    hit_eval_t        verdict;

    // per-event state
    logic signed [16:0] best_diff_u_reg, best_diff_u_next;
    logic [15:0]        best_rms_u_reg, best_rms_u_next;
    logic signed [16:0] best_diff_v_reg, best_diff_v_next;
    logic [15:0]        best_rms_v_reg, best_rms_v_next;
    logic signed [10:0] strip_u_reg, strip_u_next;
    logic signed [10:0] strip_v_reg, strip_v_next;
    logic signed [4:0]  time_u_reg, time_u_next;
    logic signed [4:0]  time_v_reg, time_v_next;
    logic [11:0]        hits_reg, hits_next;
    logic [11:0]        strong_reg, strong_next;

    logic counted_eff;
    logic take_u;
    logic take_v;

    // result register
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      out_free;
    out_data_t out_data_reg;
    out_data_t out_data_next;

    assign in_d      = in_data_t'(s_tdata);
    assign in_is_hit = (s_tuser == MODE_HIT);
    assign in_range  = (32'(in_d.channel_index) < CHANNELS);

    // a last hit needs a free result slot, everything else moves on
    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_thr_reg  <= SIGMA_THR_RST;
            strong_thr_reg <= STRONG_THR_RST;
            sector_reg     <= SECTOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SIGMA_THR:  sigma_thr_reg  <= cfg_data;
                REG_STRONG_THR: strong_thr_reg <= cfg_data;
                REG_SECTOR:     sector_reg     <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // pedestal table: load writes on accept, hit reads on accept
    sphf_ped_ram u_ped_ram (
        .clk   (clk),
        .we    (s_accept && !in_is_hit && in_range),
        .waddr (in_d.channel_index[CHAN_W-1:0]),
        .wdata ({in_d.pedestal_rms, in_d.pedestal_mean}),
        .re    (s_accept && in_is_hit),
        .raddr (in_d.channel_index[CHAN_W-1:0]),
        .rdata (ped_rdata)
    );

    // only hits occupy the input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
        begin
            s1_valid_next = in_is_hit;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && in_is_hit)
        begin
            s1_sector_reg   <= in_d.sector;
            s1_layer_reg    <= in_d.layer;
            s1_strip_reg    <= in_d.strip;
            s1_adc_reg      <= in_d.adc;
            s1_time_reg     <= in_d.time_sample;
            s1_event_reg    <= in_d.event_number;
            s1_last_reg     <= s_tlast;
            s1_in_range_reg <= in_range;
        end
    end

    // an out-of-range channel reads as zero mean and zero RMS
    assign ped_mean = s1_in_range_reg ? ped_rdata[15:0]  : 16'd0;
    assign ped_rms  = s1_in_range_reg ? ped_rdata[31:16] : 16'd0;

    sphf_hit_eval u_hit_eval (
        .mean        (ped_mean),
        .rms         (ped_rms),
        .adc         (s1_adc_reg),
        .sigma_thr   (sigma_thr_reg),
        .strong_thr  (strong_thr_reg),
        .best_diff_u (best_diff_u_reg),
        .best_rms_u  (best_rms_u_reg),
        .best_diff_v (best_diff_v_reg),
        .best_rms_v  (best_rms_v_reg),
        .verdict     (verdict)
    );

    assign counted_eff = (s1_sector_reg == sector_reg) && verdict.counted;
    assign take_u      = counted_eff && (s1_layer_reg == LAYER_U) && verdict.better_u;
    assign take_v      = counted_eff && (s1_layer_reg == LAYER_V) && verdict.better_v;

    // fold the hit into the event state
    always_comb
    begin
        best_diff_u_next = best_diff_u_reg;
        best_rms_u_next  = best_rms_u_reg;
        strip_u_next     = strip_u_reg;
        time_u_next      = time_u_reg;
        best_diff_v_next = best_diff_v_reg;
        best_rms_v_next  = best_rms_v_reg;
        strip_v_next     = strip_v_reg;
        time_v_next      = time_v_reg;
        hits_next        = hits_reg;
        strong_next      = strong_reg;

        if (counted_eff && (hits_reg != COUNT_MAX))
        begin
            hits_next = hits_reg + 12'd1;
        end
        if (counted_eff && verdict.strong_hit && (strong_reg != COUNT_MAX))
        begin
            strong_next = strong_reg + 12'd1;
        end
        if (take_u)
        begin
            best_diff_u_next = verdict.diff;
            best_rms_u_next  = ped_rms;
            strip_u_next     = $signed({1'b0, s1_strip_reg});
            time_u_next      = $signed({1'b0, s1_time_reg});
        end
        if (take_v)
        begin
            best_diff_v_next = verdict.diff;
            best_rms_v_next  = ped_rms;
            strip_v_next     = $signed({1'b0, s1_strip_reg});
            time_v_next      = $signed({1'b0, s1_time_reg});
        end
    end

    // result built from the state after the last hit
    always_comb
    begin
        out_data_next              = '0;
        out_data_next.keep_event   = !strip_u_next[10] && !strip_v_next[10];
        out_data_next.best_strip_u = strip_u_next;
        out_data_next.best_strip_v = strip_v_next;
        out_data_next.best_time_u  = time_u_next;
        out_data_next.best_time_v  = time_v_next;
        out_data_next.hit_count    = hits_next;
        out_data_next.strong_count = strong_next;
        out_data_next.event_id     = s1_event_reg;
    end

    // advance the event state; clear it once the last hit has been folded in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_diff_u_reg <= '0;
            best_rms_u_reg  <= 16'd1;
            strip_u_reg     <= STRIP_NONE;
            time_u_reg      <= TIME_NONE;
            best_diff_v_reg <= '0;
            best_rms_v_reg  <= 16'd1;
            strip_v_reg     <= STRIP_NONE;
            time_v_reg      <= TIME_NONE;
            hits_reg        <= '0;
            strong_reg      <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                best_diff_u_reg <= '0;
                best_rms_u_reg  <= 16'd1;
                strip_u_reg     <= STRIP_NONE;
                time_u_reg      <= TIME_NONE;
                best_diff_v_reg <= '0;
                best_rms_v_reg  <= 16'd1;
                strip_v_reg     <= STRIP_NONE;
                time_v_reg      <= TIME_NONE;
                hits_reg        <= '0;
                strong_reg      <= '0;
            end
            else
            begin
                best_diff_u_reg <= best_diff_u_next;
                best_rms_u_reg  <= best_rms_u_next;
                strip_u_reg     <= strip_u_next;
                time_u_reg      <= time_u_next;
                best_diff_v_reg <= best_diff_v_next;
                best_rms_v_reg  <= best_rms_v_next;
                strip_v_reg     <= strip_v_next;
                time_v_reg      <= time_v_next;
                hits_reg        <= hits_next;
                strong_reg      <= strong_next;
            end
        end
    end

    // result register: load on a firing last hit, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule

// File: sv/sphf_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the strip peak hit finder, bound to its top level.
// Depends on sphf_pkg and strip_peak_hit_finder_top_defines.svh.
`include "strip_peak_hit_finder_top_defines.svh"

module sphf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sphf_pkg::OUT_DATA_W-1:0] m_tdata
);
    import sphf_pkg::*;

    out_data_t res;

    assign res = out_data_t'(m_tdata);

    // a stalled result holds
    `SPHF_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // keep flag set exactly when both layers have a peak
    `SPHF_ASSERT_NOW(a_keep_matches, m_tvalid, res.keep_event == (!res.best_strip_u[10] && !res.best_strip_v[10]))

    // strong hits are a subset of counted hits
    `SPHF_ASSERT_NOW(a_strong_le_hits, m_tvalid, res.strong_count <= res.hit_count)

    // strip and time of the U layer are set together
    `SPHF_ASSERT_NOW(a_u_pair, m_tvalid, (res.best_strip_u == STRIP_NONE) == (res.best_time_u == TIME_NONE))

endmodule

bind strip_peak_hit_finder_top sphf_checker u_sphf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
